// ===== design/rcz_pkg.sv =====
// Shared types and constants for the RGB 3x3 zero-padded convolution block.
package rcz_pkg;

  localparam int CH_W       = 8;
  localparam int COEF_W     = 16;
  localparam int SUM_W      = 28;
  localparam int KSIZE      = 3;
  localparam int KTAPS      = KSIZE * KSIZE;
  localparam int OUT_CH     = 3;
  localparam int MAX_CH     = 4;
  localparam int IW_W       = 11;
  localparam int KROW_W     = COEF_W * KSIZE;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam int ROW_CNT_W  = 2;

  localparam logic [IW_W-1:0]      IMAGE_WIDTH_RESET = IW_W'(1024);
  localparam logic [KROW_W-1:0]    KROW_TOP_RESET    = '0;
  localparam logic [KROW_W-1:0]    KROW_MID_RESET    = KROW_W'(4096);
  localparam logic [KROW_W-1:0]    KROW_BOT_RESET    = '0;
  localparam logic [ROW_CNT_W-1:0] ROW_SAT           = ROW_CNT_W'(2);

  typedef logic [CH_W-1:0]          chan_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH = 2'd0,
    CFG_KROW_TOP    = 2'd1,
    CFG_KROW_MID    = 2'd2,
    CFG_KROW_BOT    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic adv;
    logic col_zero;
    logic emit_mid;
    logic emit_end;
    logic flush;
  } win_ctl_t;

endpackage

// ===== design/rcz_if.sv =====
// Valid/ready channel interfaces for pixels, results and configuration writes.
interface rcz_pix_if;
  import rcz_pkg::*;
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;
  logic  frame_start;
  logic  flush;
  modport source (output valid, red, green, blue, frame_start, flush, input ready);
  modport sink (input valid, red, green, blue, frame_start, flush, output ready);
endinterface

interface rcz_res_if;
  import rcz_pkg::*;
  logic valid;
  logic ready;
  sum_t red_sum;
  sum_t green_sum;
  sum_t blue_sum;
  logic row_end;
  logic frame_end;
  logic last_in_run;
  modport source (output valid, red_sum, green_sum, blue_sum, row_end, frame_end,
                  last_in_run, input ready);
  modport sink (input valid, red_sum, green_sum, blue_sum, row_end, frame_end,
                last_in_run, output ready);
endinterface

interface rcz_cfg_if;
  import rcz_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/rcz_ram.sv =====
// Simple dual-port line buffer memory with registered read data.
module rcz_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rcz_dot9.sv =====
// Nine-tap dot product of unsigned pixel samples and signed Q4.12 coefficients.
module rcz_dot9 (
  input  rcz_pkg::chan_t [rcz_pkg::KTAPS-1:0] taps,
  input  rcz_pkg::coef_t [rcz_pkg::KTAPS-1:0] coefs,
  output rcz_pkg::sum_t                       sum
);
  import rcz_pkg::*;

  localparam int PROD_W = CH_W + COEF_W + 1;

  always_comb begin
    logic signed [PROD_W-1:0] prod [KTAPS];
    logic signed [CH_W:0]     px;
    sum_t                     acc;
    acc = '0;
    for (int k = 0; k < KTAPS; k++) begin
      px      = signed'({1'b0, taps[k]});
      prod[k] = PROD_W'(px) * PROD_W'(coefs[k]);
    end
    for (int k = 0; k < KTAPS; k++) begin
      acc = acc + SUM_W'(prod[k]);
    end
    sum = acc;
  end

endmodule

// ===== design/rcz_win_out.sv =====
// 3x3 window register, pending result sequencing and the result output register.
module rcz_win_out #(
  parameter int CHANNELS = 3
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  rcz_pkg::win_ctl_t                          ctl,
  input  logic [CHANNELS*rcz_pkg::CH_W-1:0]          up_px,
  input  logic [CHANNELS*rcz_pkg::CH_W-1:0]          mid_px,
  input  logic [CHANNELS*rcz_pkg::CH_W-1:0]          low_px,
  input  logic [rcz_pkg::KSIZE-1:0][rcz_pkg::KROW_W-1:0] krow,
  output logic                                       win_free,
  rcz_res_if.source                                  out_px
);
  import rcz_pkg::*;

  localparam int PIX_W = CHANNELS * CH_W;

  logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] win_r;
  logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] view;
  logic                                   pend_mid_r;
  logic                                   pend_end_r;
  logic                                   flush_r;
  logic                                   out_vld_r;
  sum_t [OUT_CH-1:0]                      sum_r;
  logic                                   row_end_r;
  logic                                   frame_end_r;
  logic                                   last_r;
  sum_t [OUT_CH-1:0]                      sums;
  coef_t [KTAPS-1:0]                      coefs;
  logic                                   out_load;
  logic                                   busy;
  logic                                   emit;

  assign out_load = !out_vld_r || out_px.ready;
  assign busy     = pend_mid_r || pend_end_r;
  assign emit     = busy && out_load;
  assign win_free = !busy || (out_load && !(pend_mid_r && pend_end_r));

  always_comb begin
    for (int r = 0; r < KSIZE; r++) begin
      if (pend_mid_r) begin
        view[r] = win_r[r];
      end else begin
        view[r][0] = win_r[r][1];
        view[r][1] = win_r[r][2];
        view[r][2] = '0;
      end
      for (int j = 0; j < KSIZE; j++) begin
        coefs[r*KSIZE+j] = coef_t'(krow[r][j*COEF_W +: COEF_W]);
      end
    end
  end

  for (genvar ch = 0; ch < OUT_CH; ch++) begin : g_ch
    if (ch < CHANNELS) begin : g_on
      chan_t [KTAPS-1:0] taps;
      always_comb begin
        for (int r = 0; r < KSIZE; r++) begin
          for (int j = 0; j < KSIZE; j++) begin
            taps[r*KSIZE+j] = view[r][j][ch*CH_W +: CH_W];
          end
        end
      end
      rcz_dot9 u_dot (
        .taps  (taps),
        .coefs (coefs),
        .sum   (sums[ch])
      );
    end else begin : g_off
      assign sums[ch] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_mid_r <= 1'b0;
      pend_end_r <= 1'b0;
      flush_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (ctl.adv) begin
        pend_mid_r <= ctl.emit_mid;
        pend_end_r <= ctl.emit_end;
        flush_r    <= ctl.flush;
      end else if (emit) begin
        if (pend_mid_r) begin
          pend_mid_r <= 1'b0;
        end else begin
          pend_end_r <= 1'b0;
        end
      end
      if (out_load) begin
        out_vld_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int r = 0; r < KSIZE; r++) begin
        win_r[r][0] <= ctl.col_zero ? '0 : win_r[r][1];
        win_r[r][1] <= ctl.col_zero ? '0 : win_r[r][2];
      end
      win_r[0][2] <= up_px;
      win_r[1][2] <= mid_px;
      win_r[2][2] <= low_px;
    end
    if (emit) begin
      sum_r       <= sums;
      row_end_r   <= !pend_mid_r;
      frame_end_r <= !pend_mid_r && flush_r;
      last_r      <= !(pend_mid_r && pend_end_r);
    end
  end

  assign out_px.valid       = out_vld_r;
  assign out_px.red_sum     = sum_r[0];
  assign out_px.green_sum   = sum_r[1];
  assign out_px.blue_sum    = sum_r[2];
  assign out_px.row_end     = row_end_r;
  assign out_px.frame_end   = frame_end_r;
  assign out_px.last_in_run = last_r;

endmodule

// ===== design/rgb_conv3x3_zero_pad.sv =====
// Top level: streaming 3x3 RGB correlation with zero padding and two line buffers.
// An accepted pixel passes the input stage, the window register and the output register.
// Throughput: one pixel per cycle unless the output stalls or a row's last pixel,
// from the second row on, gives two results (one in a one-pixel row) for the single output register.
// Reset: control and configuration registers go to their reset values, then the
// line buffers are zeroed at every address while in_px.ready stays low.
module rgb_conv3x3_zero_pad #(
  parameter int MAX_WIDTH = 1024,
  parameter int CHANNELS  = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  rcz_cfg_if.sink   cfg_wr,
  rcz_pix_if.sink   in_px,
  rcz_res_if.source out_px
);
  import rcz_pkg::*;

  localparam int PIX_W = CHANNELS * CH_W;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = (IW_W > AW + 1) ? IW_W : AW + 1;

  logic [IW_W-1:0]              image_width_r;
  logic [KSIZE-1:0][KROW_W-1:0] krow_r;

  logic                 clr_busy_r;
  logic [AW-1:0]        clr_cnt_r;
  logic [AW-1:0]        col_r;
  logic [ROW_CNT_W-1:0] row_cnt_r;

  logic             a_vld_r;
  logic [PIX_W-1:0] a_pix_r;
  logic             a_flush_r;
  logic [AW-1:0]    a_col_r;
  logic             a_row1_r;
  logic             a_row2_r;
  logic             a_last_r;
  logic             a_byp_r;
  logic [PIX_W-1:0] a_byp_up_r;
  logic [PIX_W-1:0] a_byp_lo_r;

  logic                 accept;
  logic                 a_adv;
  logic                 win_free;
  logic [AW-1:0]        col_eff;
  logic [ROW_CNT_W-1:0] row_eff;
  logic [CW-1:0]        iw_x;
  logic [CW-1:0]        w_x;
  logic [CW-1:0]        c_plus1;
  logic                 last;
  logic [AW-1:0]        col_nxt;
  logic [ROW_CNT_W-1:0] row_cnt_nxt;
  chan_t [MAX_CH-1:0]   in_ch;
  logic [PIX_W-1:0]     in_pix;
  logic [PIX_W-1:0]     up_rd;
  logic [PIX_W-1:0]     lo_rd;
  logic [PIX_W-1:0]     raw_up;
  logic [PIX_W-1:0]     raw_lo;
  logic [PIX_W-1:0]     up_px;
  logic [PIX_W-1:0]     mid_px;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [PIX_W-1:0]     up_wdata;
  logic [PIX_W-1:0]     lo_wdata;
  win_ctl_t             ctl;

  // configuration writes
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMAGE_WIDTH_RESET;
      krow_r[0]     <= KROW_TOP_RESET;
      krow_r[1]     <= KROW_MID_RESET;
      krow_r[2]     <= KROW_BOT_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_idx_t'(cfg_wr.index))
        CFG_IMAGE_WIDTH: image_width_r <= cfg_wr.data[IW_W-1:0];
        CFG_KROW_TOP:    krow_r[0]     <= cfg_wr.data[KROW_W-1:0];
        CFG_KROW_MID:    krow_r[1]     <= cfg_wr.data[KROW_W-1:0];
        CFG_KROW_BOT:    krow_r[2]     <= cfg_wr.data[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // position tracking
  assign accept  = in_px.valid && in_px.ready;
  assign a_adv   = a_vld_r && win_free;
  assign in_px.ready = !clr_busy_r && (!a_vld_r || a_adv);

  assign col_eff = in_px.frame_start ? '0 : col_r;
  assign row_eff = in_px.frame_start ? '0 : row_cnt_r;
  assign iw_x    = CW'(image_width_r);
  assign c_plus1 = CW'(col_eff) + CW'(1);
  assign last    = c_plus1 >= w_x;

  always_comb begin
    if (iw_x == '0) begin
      w_x = CW'(1);
    end else if (iw_x > CW'(MAX_WIDTH)) begin
      w_x = CW'(MAX_WIDTH);
    end else begin
      w_x = iw_x;
    end
  end

  always_comb begin
    if (last) begin
      col_nxt     = '0;
      row_cnt_nxt = (row_eff == ROW_SAT) ? ROW_SAT : row_eff + ROW_CNT_W'(1);
    end else begin
      col_nxt     = AW'(c_plus1);
      row_cnt_nxt = row_eff;
    end
  end

  always_comb begin
    in_ch    = '0;
    in_ch[0] = in_px.red;
    in_ch[1] = in_px.green;
    in_ch[2] = in_px.blue;
    in_pix   = '0;
    if (!in_px.flush) begin
      for (int k = 0; k < CHANNELS; k++) begin
        in_pix[k*CH_W +: CH_W] = in_ch[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      col_r      <= '0;
      row_cnt_r  <= '0;
      a_vld_r    <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        if (clr_cnt_r == AW'(MAX_WIDTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (accept) begin
        col_r     <= col_nxt;
        row_cnt_r <= row_cnt_nxt;
      end
      if (accept) begin
        a_vld_r <= 1'b1;
      end else if (a_adv) begin
        a_vld_r <= 1'b0;
      end
    end
  end

  // input stage: hold item, capture write data when the pending write hits the read
  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix_r    <= in_pix;
      a_flush_r  <= in_px.flush;
      a_col_r    <= col_eff;
      a_row1_r   <= row_eff != '0;
      a_row2_r   <= row_eff == ROW_SAT;
      a_last_r   <= last;
      a_byp_r    <= a_adv && (a_col_r == col_eff);
      a_byp_up_r <= raw_lo;
      a_byp_lo_r <= a_pix_r;
    end
  end

  assign raw_up = a_byp_r ? a_byp_up_r : up_rd;
  assign raw_lo = a_byp_r ? a_byp_lo_r : lo_rd;
  assign up_px  = a_row2_r ? raw_up : '0;
  assign mid_px = a_row1_r ? raw_lo : '0;

  assign ram_we    = clr_busy_r || a_adv;
  assign ram_waddr = clr_busy_r ? clr_cnt_r : a_col_r;
  assign up_wdata  = clr_busy_r ? '0 : raw_lo;
  assign lo_wdata  = clr_busy_r ? '0 : a_pix_r;

  rcz_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PIX_W)
  ) u_lb_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (up_wdata),
    .re    (accept),
    .raddr (col_eff),
    .rdata (up_rd)
  );

  rcz_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (PIX_W)
  ) u_lb_lower (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (lo_wdata),
    .re    (accept),
    .raddr (col_eff),
    .rdata (lo_rd)
  );

  assign ctl.adv      = a_adv;
  assign ctl.col_zero = a_col_r == '0;
  assign ctl.emit_mid = a_row1_r && (a_col_r != '0);
  assign ctl.emit_end = a_row1_r && a_last_r;
  assign ctl.flush    = a_flush_r;

  rcz_win_out #(
    .CHANNELS (CHANNELS)
  ) u_win_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .up_px    (up_px),
    .mid_px   (mid_px),
    .low_px   (a_pix_r),
    .krow     (krow_r),
    .win_free (win_free),
    .out_px   (out_px)
  );

endmodule

// ===== tb/sv/rcz_conv_checker.sv =====
// Checker for the RGB 3x3 correlation block: predicts each filtered pixel and compares results.
module rcz_conv_checker
  import rcz_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rcz_cfg_if   cfg_wr,
  rcz_pix_if   in_px,
  rcz_res_if   out_px,
  output int   mismatch_count,
  output int   expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH = 1024;
  localparam int ROW_LIMIT  = 4095;
  localparam int SHOW_MAX   = 10;

  typedef logic [OUT_CH*CH_W-1:0] rgb_t;

  typedef struct {
    sum_t red_sum;
    sum_t green_sum;
    sum_t blue_sum;
    logic row_end;
    logic frame_end;
    logic last_in_run;
  } filtered_t;

  rgb_t              upper_row [LINE_DEPTH];
  rgb_t              lower_row [LINE_DEPTH];
  rgb_t              win [KSIZE][KSIZE];
  int unsigned       col_pos;
  int unsigned       row_pos;
  logic [IW_W-1:0]   width_reg;
  logic [KROW_W-1:0] krow [KSIZE];
  filtered_t         filtered_q [$];
  int                fails;

  task automatic shift_window(input rgb_t up, input rgb_t mid, input rgb_t low);
    for (int r = 0; r < KSIZE; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = low;
  endtask

  function automatic sum_t channel_sum(input int ch);
    int    acc;
    int    p;
    int    k;
    coef_t coef;
    acc = 0;
    for (int i = 0; i < KSIZE; i++) begin
      for (int j = 0; j < KSIZE; j++) begin
        coef = krow[i][COEF_W*j +: COEF_W];
        k    = coef;
        p    = win[i][j][CH_W*ch +: CH_W];
        acc += p * k;
      end
    end
    return sum_t'(acc);
  endfunction

  function automatic filtered_t window_result(input logic row_end, input logic frame_end);
    filtered_t f;
    f.red_sum     = channel_sum(0);
    f.green_sum   = channel_sum(1);
    f.blue_sum    = channel_sum(2);
    f.row_end     = row_end;
    f.frame_end   = frame_end;
    f.last_in_run = 1'b0;
    return f;
  endfunction

  task automatic correlate_pixel(input rgb_t pix_in, input logic fs, input logic fl);
    rgb_t        pix;
    rgb_t        up;
    rgb_t        mid;
    int unsigned w;
    int unsigned c;
    bit          last;
    bit          have_mid;
    filtered_t   mid_res;
    filtered_t   end_res;
    pix      = fl ? '0 : pix_in;
    have_mid = 1'b0;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    w = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
    c = (col_pos < LINE_DEPTH) ? col_pos : LINE_DEPTH - 1;
    up  = (row_pos >= 2) ? upper_row[c] : '0;
    mid = (row_pos >= 1) ? lower_row[c] : '0;
    shift_window(up, mid, pix);
    if (c == 0) begin
      for (int r = 0; r < KSIZE; r++) begin
        win[r][0] = '0;
        win[r][1] = '0;
      end
    end
    upper_row[c] = lower_row[c];
    lower_row[c] = pix;
    last = (c + 1 >= w);
    if (row_pos >= 1) begin
      if (c >= 1) begin
        mid_res  = window_result(1'b0, 1'b0);
        have_mid = 1'b1;
      end
      if (last) begin
        shift_window('0, '0, '0);
        end_res = window_result(1'b1, fl);
        end_res.last_in_run = 1'b1;
      end else if (have_mid) begin
        mid_res.last_in_run = 1'b1;
      end
      if (have_mid) filtered_q.push_back(mid_res);
      if (last) filtered_q.push_back(end_res);
    end
    if (last) begin
      col_pos = 0;
      if (row_pos < ROW_LIMIT) row_pos++;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic flag_result(input string why, input filtered_t want, input filtered_t got);
    fails++;
    if (fails <= SHOW_MAX) begin
      $display("%0t result %s: expected r=%0d g=%0d b=%0d row_end=%b frame_end=%b last=%b",
               $realtime, why, want.red_sum, want.green_sum, want.blue_sum,
               want.row_end, want.frame_end, want.last_in_run);
      $display("%0t          got      r=%0d g=%0d b=%0d row_end=%b frame_end=%b last=%b",
               $realtime, got.red_sum, got.green_sum, got.blue_sum,
               got.row_end, got.frame_end, got.last_in_run);
    end
  endtask

  always @(posedge clk) begin
    filtered_t want;
    filtered_t got;
    if (!rst_n) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      for (int r = 0; r < KSIZE; r++) begin
        for (int j = 0; j < KSIZE; j++) win[r][j] = '0;
      end
      col_pos   = 0;
      row_pos   = 0;
      width_reg = IMAGE_WIDTH_RESET;
      krow[0]   = KROW_TOP_RESET;
      krow[1]   = KROW_MID_RESET;
      krow[2]   = KROW_BOT_RESET;
      filtered_q.delete();
      fails = 0;
    end else begin
      if (cfg_wr.valid && cfg_wr.ready) begin
        case (cfg_wr.index)
          CFG_IMAGE_WIDTH: width_reg = cfg_wr.data[IW_W-1:0];
          CFG_KROW_TOP:    krow[0]   = cfg_wr.data[KROW_W-1:0];
          CFG_KROW_MID:    krow[1]   = cfg_wr.data[KROW_W-1:0];
          CFG_KROW_BOT:    krow[2]   = cfg_wr.data[KROW_W-1:0];
          default: ;
        endcase
      end
      if (in_px.valid && in_px.ready) begin
        correlate_pixel({in_px.blue, in_px.green, in_px.red}, in_px.frame_start, in_px.flush);
      end
      if (out_px.valid && out_px.ready) begin
        got.red_sum     = out_px.red_sum;
        got.green_sum   = out_px.green_sum;
        got.blue_sum    = out_px.blue_sum;
        got.row_end     = out_px.row_end;
        got.frame_end   = out_px.frame_end;
        got.last_in_run = out_px.last_in_run;
        if (filtered_q.size() == 0) begin
          want = '{default: 'x};
          flag_result("unexpected", want, got);
        end else begin
          want = filtered_q.pop_front();
          if (want.red_sum !== got.red_sum || want.green_sum !== got.green_sum ||
              want.blue_sum !== got.blue_sum || want.row_end !== got.row_end ||
              want.frame_end !== got.frame_end || want.last_in_run !== got.last_in_run) begin
            flag_result("mismatch", want, got);
          end
        end
      end
    end
    mismatch_count <= fails;
    expected_left  <= filtered_q.size();
  end

endmodule

// ===== tb/sv/rgb_conv3x3_zero_pad_tb.sv =====
// Testbench top for the RGB 3x3 correlation block: clock, reset, stimulus and verdict.
module rgb_conv3x3_zero_pad_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rcz_pkg::*;

  localparam int LINE_DEPTH     = 1024;
  localparam int IDLE_PCT       = 29;
  localparam int STALL_SPAN     = 300;
  localparam int STALL_AT       = 10;
  localparam int SHORT_WIDTH    = 40;
  localparam int SHORT_ROWS     = 3;
  localparam int RANDOM_ITEMS   = 600;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst_n;
  bit   steady;
  int   stall_cycles;
  int   sent_items;
  int   quiet_cycles;
  int   mismatch_count;
  int   expected_left;

  rcz_cfg_if cfg_wr ();
  rcz_pix_if in_px ();
  rcz_res_if out_px ();

  rgb_conv3x3_zero_pad #(
    .MAX_WIDTH(LINE_DEPTH),
    .CHANNELS (OUT_CH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_wr(cfg_wr),
    .in_px (in_px),
    .out_px(out_px)
  );

  rcz_conv_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr        (cfg_wr),
    .in_px         (in_px),
    .out_px        (out_px),
    .mismatch_count(mismatch_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result sink: random back-pressure, with one long hold-off
  initial begin
    out_px.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (stall_cycles > 0) begin
        out_px.ready = 1'b0;
        stall_cycles--;
      end else begin
        out_px.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_px.valid && in_px.ready) || (out_px.valid && out_px.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr.valid = 1'b1;
    cfg_wr.index = idx;
    cfg_wr.data  = value;
    do @(posedge clk); while (!cfg_wr.ready);
    @(negedge clk);
    cfg_wr.valid = 1'b0;
  endtask

  task automatic write_kernel(input logic [KROW_W-1:0] top, input logic [KROW_W-1:0] mid,
                              input logic [KROW_W-1:0] bot);
    write_reg(CFG_KROW_TOP, CFG_DATA_W'(top));
    write_reg(CFG_KROW_MID, CFG_DATA_W'(mid));
    write_reg(CFG_KROW_BOT, CFG_DATA_W'(bot));
  endtask

  function automatic logic [KROW_W-1:0] rand_krow();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
                            input logic fs, input logic fl);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_px.valid = 1'b0;
      @(negedge clk);
    end
    in_px.valid       = 1'b1;
    in_px.red         = r;
    in_px.green       = g;
    in_px.blue        = b;
    in_px.frame_start = fs;
    in_px.flush       = fl;
    do @(posedge clk); while (!in_px.ready);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic send_rand(input logic fs, input logic fl);
    send_pixel(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom), fs, fl);
  endtask

  task automatic send_frame(input int w, input int rows);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < w; c++) send_rand(r == 0 && c == 0, 1'b0);
    end
    for (int c = 0; c < w; c++) send_rand(1'b0, 1'b1);
  endtask

  task automatic wait_idle();
    in_px.valid = 1'b0;
    while (expected_left != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int w;
    int kind;
    int base;
    rst_n             = 1'b0;
    steady            = 1'b0;
    stall_cycles      = 0;
    sent_items        = 0;
    in_px.valid       = 1'b0;
    in_px.red         = '0;
    in_px.green       = '0;
    in_px.blue        = '0;
    in_px.frame_start = 1'b0;
    in_px.flush       = 1'b0;
    cfg_wr.valid      = 1'b0;
    cfg_wr.index      = CFG_IMAGE_WIDTH;
    cfg_wr.data       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset kernel on a narrow frame; hold off results during the flush row
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(SHORT_WIDTH));
    for (int r = 0; r < SHORT_ROWS; r++) begin
      for (int c = 0; c < SHORT_WIDTH; c++) send_rand(r == 0 && c == 0, 1'b0);
    end
    for (int c = 0; c < SHORT_WIDTH; c++) begin
      if (c == STALL_AT) stall_cycles = STALL_SPAN;
      send_rand(1'b0, 1'b1);
    end
    wait_idle();

    // over-range width on the row after a one-pixel row, no gaps on either side
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(1));
    write_kernel(rand_krow(), rand_krow(), rand_krow());
    send_rand(1'b1, 1'b0);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(2047));
    steady = 1'b1;
    for (int c = 0; c < LINE_DEPTH; c++) send_rand(1'b0, 1'b0);
    steady = 1'b0;
    wait_idle();

    // width one, largest positive coefficients
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(1));
    write_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    send_pixel(8'hA5, 8'h5A, 8'hFF, 1'b0, 1'b1);
    wait_idle();

    // most negative coefficients on a saturated image
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
    write_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, 8'hFF, 8'hFF, i == 0, 1'b0);
    for (int i = 0; i < 3; i++) send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1);
    wait_idle();

    // zero width taken as one, black pixels
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(0));
    write_kernel({16'h0001, 16'hF000, 16'h1000}, {16'h7FFF, 16'h8000, 16'h0000},
                 {16'hFFFF, 16'h0800, 16'h4000});
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
    wait_idle();

    // shrink the width mid-row
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(5));
    for (int i = 0; i < 8; i++) send_rand(i == 0, 1'b0);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(2));
    send_rand(1'b0, 1'b0);
    send_rand(1'b0, 1'b0);
    wait_idle();

    base = sent_items;
    while (sent_items - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = $urandom_range(13, 64);
        default: w = $urandom_range(1, 12);
      endcase
      write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
      if ($urandom_range(0, 99) < 60) write_reg(CFG_KROW_TOP, CFG_DATA_W'(rand_krow()));
      if ($urandom_range(0, 99) < 60) write_reg(CFG_KROW_MID, CFG_DATA_W'(rand_krow()));
      if ($urandom_range(0, 99) < 60) write_reg(CFG_KROW_BOT, CFG_DATA_W'(rand_krow()));
      if (w == 0) w = 1;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        repeat ($urandom_range(1, 2)) send_frame(w, $urandom_range(1, 4));
      end else if (kind < 85) begin
        send_rand(1'b1, 1'b0);
        repeat ($urandom_range(1, 3 * w)) send_rand(1'b0, 1'b0);
      end else begin
        repeat ($urandom_range(5, 30)) begin
          send_rand($urandom_range(0, 19) == 0, $urandom_range(0, 3) == 0);
        end
      end
      wait_idle();
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_left == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== rgb_conv3x3_zero_pad.f =====
design/rcz_pkg.sv
design/rcz_if.sv
design/rcz_ram.sv
design/rcz_dot9.sv
design/rcz_win_out.sv
design/rgb_conv3x3_zero_pad.sv
tb/sv/rcz_conv_checker.sv
tb/sv/rgb_conv3x3_zero_pad_tb.sv
